[hw/rtl/wildcard_byte_signature_scanner_core_defines.svh]
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner: assertion macros
// Shared assertion forms. Each expects clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_SIGNATURE_SCANNER_CORE_DEFINES_SVH
`define WILDCARD_BYTE_SIGNATURE_SCANNER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WBSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WBSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wbss_pkg.sv]
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner package
// Word types, register indexes and sizing constants shared by all modules.
// ----------------------------------------------------------------------------
package wbss_pkg;

    // Default depth of the byte window.
    localparam int MAX_PATTERN_BYTES = 16;
    // Signature bytes held by the pattern registers.
    localparam int PATTERN_BYTES     = 16;
    localparam int PATTERN_IDX_W     = 4;
    localparam int COUNT_W           = 32;
    localparam int ADDR_W            = 64;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 4;
    // Entries in the event queue between front and back.
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 4'd0,
        CFG_PATTERN_HIGH   = 4'd1,
        CFG_CARE_MASK      = 4'd2,
        CFG_PATTERN_LENGTH = 4'd3,
        CFG_RESULT_OFFSET  = 4'd4,
        CFG_REGION_BASE    = 4'd5,
        CFG_SCAN_LIMIT     = 4'd6,
        CFG_SUBTRACT_BASE  = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } scan_word_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } result_word_t;

    // What the front hands to the back: a hit with its start offset, or the
    // end of a region that had no hit.
    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] start;
    } scan_event_t;

endpackage

[hw/rtl/wildcard_byte_signature_scanner_core.sv]
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner core
// Streams the bytes of a memory region and reports the first start offset at
// which a signature with wildcard positions matches, or that none matched.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Word
//  --------  ---------  ------------------------  ---------------------------
//  scan      in         scan_valid / scan_stall   data_byte, last_byte
//  result    out        result_valid/result_stall found, match_address
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One byte is taken every cycle while scan_stall is low; the window
// compare is a single parallel stage in the front, so the sustained
// rate is one word per clock. A result passes the front, which classifies
// the byte, the two-entry event queue, which holds it, and the back, which
// adds the address into the output register.
// scan_stall is high while the event queue is full, for the first cycle out
// of reset, and for one cycle after each configuration write, while the
// aligned signature and address base registers take up the new values.
// Reset clears the configuration to its defaults and the search state.
//
// ----------------------------------------------------------------------------
`include "wildcard_byte_signature_scanner_core_defines.svh"

module wildcard_byte_signature_scanner_core #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 scan_valid,
    output logic                                 scan_stall,
    input  wbss_pkg::scan_word_t                 scan_data,

    output logic                                 result_valid,
    input  logic                                 result_stall,
    output wbss_pkg::result_word_t               result_data,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wbss_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int AW    = wbss_pkg::ADDR_W;
    localparam int CW    = wbss_pkg::COUNT_W;

    // Configuration registers.
    logic [63:0]   pattern_low_reg;
    logic [63:0]   pattern_high_reg;
    logic [15:0]   care_mask_reg;
    logic [4:0]    pattern_length_reg;
    logic [31:0]   result_offset_reg;
    logic [AW-1:0] region_base_reg;
    logic [CW-1:0] scan_limit_reg;
    logic          subtract_base_reg;

    // Values derived from the configuration, registered so that the front
    // compares every window position against a fixed expected byte.
    logic [MAX_PATTERN_BYTES*8-1:0] expect_bytes_reg, expect_bytes_next;
    logic [MAX_PATTERN_BYTES-1:0]   expect_care_reg, expect_care_next;
    logic [LEN_W-1:0]               length_m1_reg, length_m1_next;
    logic [AW-1:0]                  offset_base_reg, offset_base_next;
    logic                           settle_reg;

    logic                           cfg_write;
    logic                           scan_take;
    logic                           queue_full;
    logic                           queue_not_empty;
    logic                           queue_pop;
    logic                           front_push;
    wbss_pkg::scan_event_t          front_event;
    wbss_pkg::scan_event_t          queue_head;

    logic [127:0]                   pattern_all;
    logic                           length_zero;
    logic [LEN_W-1:0]               length_eff;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= 5'd1;
            result_offset_reg  <= '0;
            region_base_reg    <= '0;
            scan_limit_reg     <= '0;
            subtract_base_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wbss_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                wbss_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                wbss_pkg::CFG_CARE_MASK:      care_mask_reg      <= cfg_data[15:0];
                wbss_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[4:0];
                wbss_pkg::CFG_RESULT_OFFSET:  result_offset_reg  <= cfg_data[31:0];
                wbss_pkg::CFG_REGION_BASE:    region_base_reg    <= cfg_data;
                wbss_pkg::CFG_SCAN_LIMIT:     scan_limit_reg     <= cfg_data[CW-1:0];
                wbss_pkg::CFG_SUBTRACT_BASE:  subtract_base_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A length of zero compares nothing and behaves as a length of one; a
    // length beyond the window saturates to the window depth.
    assign pattern_all = {pattern_high_reg, pattern_low_reg};
    assign length_zero = (pattern_length_reg == 5'd0);

    always_comb
    begin
        if (length_zero)
        begin
            length_eff = LEN_W'(1);
        end
        else if (32'(pattern_length_reg) > 32'(MAX_PATTERN_BYTES))
        begin
            length_eff = LEN_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            length_eff = LEN_W'(pattern_length_reg);
        end
        length_m1_next = length_eff - LEN_W'(1);
    end

    // Window position j holds the byte that lines up with signature byte
    // (length - 1 - j). Positions past the signature registers are wildcards.
    always_comb
    begin
        int sig_pos;
        sig_pos = 0;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            sig_pos = 32'(length_m1_next) - j;
            expect_bytes_next[j*8 +: 8] = pattern_all[sig_pos[3:0]*8 +: 8];
            expect_care_next[j] = !length_zero && (sig_pos >= 0)
                                && (sig_pos < wbss_pkg::PATTERN_BYTES)
                                && care_mask_reg[sig_pos[wbss_pkg::PATTERN_IDX_W-1:0]];
        end
    end

    assign offset_base_next = (subtract_base_reg ? '0 : region_base_reg)
                            + AW'(result_offset_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= 1'b1;
        end
        else
        begin
            settle_reg <= cfg_write;
        end
    end

    always_ff @(posedge clk)
    begin
        expect_bytes_reg <= expect_bytes_next;
        expect_care_reg  <= expect_care_next;
        length_m1_reg    <= length_m1_next;
        offset_base_reg  <= offset_base_next;
    end

    // The front waits for room in the queue and for the configuration to settle, never for the output.
    assign scan_stall = queue_full || settle_reg;
    assign scan_take  = scan_valid && !scan_stall;

    wbss_front #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .LEN_W             (LEN_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (scan_take),
        .scan_word    (scan_data),
        .expect_bytes (expect_bytes_reg),
        .expect_care  (expect_care_reg),
        .length_m1    (length_m1_reg),
        .scan_limit   (scan_limit_reg),
        .push         (front_push),
        .push_event   (front_event)
    );

    wbss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_event (front_event),
        .pop        (queue_pop),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .head_event (queue_head)
    );

    wbss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (queue_not_empty),
        .head_event   (queue_head),
        .offset_base  (offset_base_reg),
        .pop          (queue_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    `WBSS_ASSERT_NEXT(a_core_settle_after_cfg, cfg_write, scan_stall,
        "byte taken before the configuration settled")
    `WBSS_ASSERT_SAME(a_core_no_address_on_miss,
        result_valid && !result_data.found, result_data.match_address == '0,
        "nonzero address reported for a region without a match")

endmodule

[hw/rtl/wbss_queue.sv]
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner event queue
// Small register FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "wildcard_byte_signature_scanner_core_defines.svh"

module wbss_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wbss_pkg::scan_event_t push_event,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output wbss_pkg::scan_event_t head_event
);

    localparam int DEPTH = wbss_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wbss_pkg::scan_event_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_event = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_event;
        end
    end

    `WBSS_ASSERT_SAME(a_queue_no_overflow, push, count_reg != CNT_W'(DEPTH),
        "event pushed into a full queue")
    `WBSS_ASSERT_SAME(a_queue_no_underflow, pop, count_reg != '0,
        "event popped from an empty queue")

endmodule

[hw/rtl/wbss_front.sv]
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner front
// Keeps the byte window and offset count, and classifies each byte as a hit,
// a region end without a hit, or nothing.
// ----------------------------------------------------------------------------
`include "wildcard_byte_signature_scanner_core_defines.svh"

module wbss_front #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES,
    parameter int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  wbss_pkg::scan_word_t           scan_word,
    input  logic [MAX_PATTERN_BYTES*8-1:0] expect_bytes,
    input  logic [MAX_PATTERN_BYTES-1:0]   expect_care,
    input  logic [LEN_W-1:0]               length_m1,
    input  logic [wbss_pkg::COUNT_W-1:0]   scan_limit,
    output logic                           push,
    output wbss_pkg::scan_event_t          push_event
);

    localparam int CW = wbss_pkg::COUNT_W;

    logic [7:0]    window_reg [MAX_PATTERN_BYTES];
    logic [7:0]    window_new [MAX_PATTERN_BYTES];
    logic [CW-1:0] seen_reg, seen_next;
    logic          done_reg, done_next;
    logic          active;
    logic          in_range;
    logic          window_hit;
    logic          hit;
    logic [CW-1:0] start;

    // Window position 0 holds the newest byte.
    always_comb
    begin
        window_new[0] = scan_word.data_byte;
        for (int j = 1; j < MAX_PATTERN_BYTES; j++)
        begin
            window_new[j] = window_reg[j-1];
        end
    end

    // The expected bytes are already aligned to window positions, so every
    // compare sits at a fixed place.
    always_comb
    begin
        window_hit = 1'b1;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            if (expect_care[j] && (window_new[j] != expect_bytes[j*8 +: 8]))
            begin
                window_hit = 1'b0;
            end
        end
    end

    assign active   = !done_reg && (seen_reg != '1);
    assign start    = seen_reg - CW'(length_m1);
    assign in_range = (seen_reg >= CW'(length_m1)) && (start < scan_limit);
    assign hit      = active && in_range && window_hit;

    assign push             = take && (hit || (scan_word.last_byte && !done_reg));
    assign push_event.found = hit;
    assign push_event.start = start;

    always_comb
    begin
        seen_next = seen_reg;
        done_next = done_reg;
        if (take)
        begin
            if (scan_word.last_byte)
            begin
                seen_next = '0;
                done_next = 1'b0;
            end
            else
            begin
                seen_next = active ? seen_reg + CW'(1) : seen_reg;
                done_next = done_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            done_reg <= done_next;
        end
    end

    // Only positions up to the length, all filled within the current region,
    // are ever compared, so the window needs no clearing.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int j = 0; j < MAX_PATTERN_BYTES; j++)
            begin
                window_reg[j] <= window_new[j];
            end
        end
    end

    `WBSS_ASSERT_NEXT(a_front_hit_ends_search, take && hit && !scan_word.last_byte,
        done_reg, "search still open after a reported hit")
    `WBSS_ASSERT_SAME(a_front_one_result, take && done_reg && !scan_word.last_byte,
        !push, "result raised after the region was already answered")

endmodule

[hw/rtl/wbss_back.sv]
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner back
// Turns queued events into result words and holds them in the output register.
// ----------------------------------------------------------------------------
module wbss_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         event_valid,
    input  wbss_pkg::scan_event_t        head_event,
    input  logic [wbss_pkg::ADDR_W-1:0]  offset_base,
    output logic                         pop,
    output logic                         result_valid,
    input  logic                         result_stall,
    output wbss_pkg::result_word_t       result_data
);

    localparam int AW = wbss_pkg::ADDR_W;

    logic                   valid_reg, valid_next;
    wbss_pkg::result_word_t data_reg, data_next;

    assign pop = event_valid && (!valid_reg || !result_stall);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (pop)
        begin
            valid_next               = 1'b1;
            data_next.found          = head_event.found;
            data_next.match_address  = head_event.found
                                     ? offset_base + AW'(head_event.start)
                                     : '0;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule
